@@ hdl/chl_pkg.sv @@
// Package for the chained hash lookup table: sizes, codes, payload and
// memory request types shared by the modulo unit, the entry store and the top level.
// Depends on nothing.
package chl_pkg;

    // Table geometry: buckets first, then an equal overflow area
    localparam int MAX_ENTRIES = 256;
    localparam int SLOTS       = 2 * MAX_ENTRIES;
    localparam int BKT_W       = $clog2(MAX_ENTRIES);
    localparam int IDX_W       = $clog2(SLOTS);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int SIZE_W      = 9;
    localparam int KEY_W       = 16;
    localparam int ADDR_W      = 32;

    // Modulo unit: key bits consumed per cycle and cycles per key
    localparam int MOD_BITS    = 4;
    localparam int MOD_CYC     = KEY_W / MOD_BITS;
    localparam int MOD_CNT_W   = $clog2(MOD_CYC);

    // Opcodes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HASH,
        S_WALK,
        S_LINK
    } t_state;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [KEY_W-1:0]  key;
        logic [ADDR_W-1:0] code_addr;
    } t_item;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] result_addr;
        logic [1:0]        status;
    } t_result;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [ADDR_W-1:0] addr;
    } t_data;

    typedef struct packed {
        logic             has_next;
        logic [IDX_W-1:0] next;
    } t_link;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             d_we;
        logic [IDX_W-1:0] d_waddr;
        t_data            d_wdata;
        logic             l_we;
        logic [IDX_W-1:0] l_waddr;
        t_link            l_wdata;
    } t_store_req;

    typedef struct packed {
        t_data data;
        t_link link;
    } t_store_rsp;

endpackage

@@ hdl/chl_mod.sv @@
// Modulo unit: remainder of the 16-bit key by the effective table size,
// restoring division at MOD_BITS key bits per cycle. Depends on chl_pkg.
module chl_mod
    import chl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [SIZE_W-1:0] i_div,
    output logic              o_done,
    output logic [BKT_W-1:0]  o_rem
);

    logic                 r_busy;
    logic                 r_done;
    logic [MOD_CNT_W-1:0] r_cnt;
    logic [KEY_W-1:0]     r_key;
    logic [BKT_W-1:0]     r_rem;
    logic [SIZE_W-1:0]    r_div;
    logic [KEY_W-1:0]     n_key;
    logic [BKT_W-1:0]     n_rem;

    // Shift in key bits and subtract the divisor where it fits
    always_comb begin
        logic [BKT_W:0] t;
        n_rem = r_rem;
        n_key = r_key;
        t     = '0;
        for (int i = 0; i < MOD_BITS; i++) begin
            t = {n_rem, n_key[KEY_W-1]};
            if (t >= r_div) begin
                t = t - r_div;
            end
            n_rem = t[BKT_W-1:0];
            n_key = {n_key[KEY_W-2:0], 1'b0};
        end
    end

    // Control: count the iterations while busy, then pulse done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + MOD_CNT_W'(1);
                if (r_cnt == MOD_CNT_W'(MOD_CYC - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load on start, iterate while busy
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key <= i_key;
            r_rem <= '0;
            r_div <= i_div;
        end else if (r_busy) begin
            r_key <= n_key;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ hdl/chl_store.sv @@
// Entry store: key/address memory and link memory, one write port each and a
// shared registered read port. Depends on chl_pkg.
module chl_store
    import chl_pkg::*;
(
    input  logic       i_clk,
    input  t_store_req i_req,
    output t_store_rsp o_rd
);

    t_data r_data_mem [SLOTS];
    t_link r_link_mem [SLOTS];

    // Write key and address of a new entry
    always_ff @(posedge i_clk) begin
        if (i_req.d_we) begin
            r_data_mem[i_req.d_waddr] <= i_req.d_wdata;
        end
    end

    // Write chain links
    always_ff @(posedge i_clk) begin
        if (i_req.l_we) begin
            r_link_mem[i_req.l_waddr] <= i_req.l_wdata;
        end
    end

    // Read one entry into the registered output
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            o_rd.data <= r_data_mem[i_req.rd_addr];
            o_rd.link <= r_link_mem[i_req.rd_addr];
        end
    end

endmodule

@@ hdl/chained_hash_lookup_table.sv @@
// Top level of the chained hash lookup table: command port, control sequencer,
// bucket valid bits and counters. Depends on chl_pkg, chl_mod and chl_store.
//
// One transaction at a time: for a lookup or a non-full insert, busy is high
// from the cycle after start is taken until the result strobe o_done, which
// lasts one cycle and cannot be held off; a new start may be taken in the strobe
// cycle. Clear and unused opcodes answer on the next cycle, as does an insert
// into a full table. Insert and lookup go through the modulo unit (four key
// bits a cycle) and then walk the chain one entry per cycle through the
// registered read port of the entry store. Bucket valid bits are flip-flops and
// overflow nodes are tracked by a fill count, so reset and clear take effect at
// once with no sweep of the memory.
module chained_hash_lookup_table
    import chl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_item             i_item,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_data,
    output logic              o_done,
    output t_result           o_result
);

    t_state                 r_state;
    t_state                 n_state;
    logic [1:0]             r_opcode;
    logic [KEY_W-1:0]       r_key;
    logic [ADDR_W-1:0]      r_addr;
    logic [IDX_W-1:0]       r_cur;
    logic [IDX_W-1:0]       n_cur;
    logic [MAX_ENTRIES-1:0] r_bkt_valid;
    logic [MAX_ENTRIES-1:0] n_bkt_valid;
    logic [CNT_W-1:0]       r_icount;
    logic [CNT_W-1:0]       n_icount;
    logic [CNT_W-1:0]       r_fill;
    logic [CNT_W-1:0]       n_fill;
    logic [SIZE_W-1:0]      r_table_size;
    logic                   r_done;
    logic                   n_done;
    t_result                r_result;
    t_result                n_result;

    logic                   w_accept;
    logic [SIZE_W-1:0]      w_eff_size;
    logic                   w_full;
    logic                   w_ovf_full;
    logic [IDX_W-1:0]       w_node;
    logic                   w_mod_start;
    logic                   w_mod_done;
    logic [BKT_W-1:0]       w_mod_rem;
    logic                   w_bkt_hit;
    logic                   w_key_match;
    t_store_req             w_req;
    t_store_rsp             w_rd;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    // Clamp the configured size to one bucket at least and the table at most
    always_comb begin
        if (r_table_size == '0) begin
            w_eff_size = SIZE_W'(1);
        end else if (r_table_size > SIZE_W'(MAX_ENTRIES)) begin
            w_eff_size = SIZE_W'(MAX_ENTRIES);
        end else begin
            w_eff_size = r_table_size;
        end
    end

    assign w_full      = (SIZE_W'(r_icount) >= w_eff_size);
    assign w_ovf_full  = (r_fill >= CNT_W'(MAX_ENTRIES));
    assign w_node      = IDX_W'(MAX_ENTRIES) + IDX_W'(r_fill);
    assign w_bkt_hit   = r_bkt_valid[w_mod_rem];
    assign w_key_match = (w_rd.data.key == r_key);

    chl_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mod_start),
        .i_key   (i_item.key),
        .i_div   (w_eff_size),
        .o_done  (w_mod_done),
        .o_rem   (w_mod_rem)
    );

    chl_store u_store (
        .i_clk (i_clk),
        .i_req (w_req),
        .o_rd  (w_rd)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_item.opcode == OP_LOOKUP) begin
                        n_state = S_HASH;
                    end else if (i_item.opcode == OP_INSERT && !w_full) begin
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH: begin
                if (w_mod_done) begin
                    n_state = w_bkt_hit ? S_WALK : S_IDLE;
                end
            end
            S_WALK: begin
                if (r_opcode == OP_LOOKUP) begin
                    if (w_key_match || !w_rd.link.has_next) begin
                        n_state = S_IDLE;
                    end
                end else if (!w_rd.link.has_next) begin
                    n_state = w_ovf_full ? S_IDLE : S_LINK;
                end
            end
            S_LINK: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Memory requests, counter updates and results
    always_comb begin
        n_done      = 1'b0;
        n_result    = '0;
        n_cur       = r_cur;
        n_bkt_valid = r_bkt_valid;
        n_icount    = r_icount;
        n_fill      = r_fill;
        w_mod_start = 1'b0;
        w_req       = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_item.opcode)
                        OP_CLEAR: begin
                            n_bkt_valid = '0;
                            n_icount    = '0;
                            n_fill      = '0;
                            n_done      = 1'b1;
                        end
                        OP_INSERT: begin
                            if (w_full) begin
                                n_done          = 1'b1;
                                n_result.status = ST_FULL;
                            end else begin
                                w_mod_start = 1'b1;
                            end
                        end
                        OP_LOOKUP: begin
                            w_mod_start = 1'b1;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_HASH: begin
                if (w_mod_done) begin
                    if (w_bkt_hit) begin
                        // Fetch the bucket head
                        w_req.rd_en   = 1'b1;
                        w_req.rd_addr = IDX_W'(w_mod_rem);
                        n_cur         = IDX_W'(w_mod_rem);
                    end else if (r_opcode == OP_LOOKUP) begin
                        n_done          = 1'b1;
                        n_result.status = ST_MISS;
                    end else begin
                        // Fill the empty bucket
                        w_req.d_we             = 1'b1;
                        w_req.d_waddr          = IDX_W'(w_mod_rem);
                        w_req.d_wdata.key      = r_key;
                        w_req.d_wdata.addr     = r_addr;
                        w_req.l_we             = 1'b1;
                        w_req.l_waddr          = IDX_W'(w_mod_rem);
                        n_bkt_valid[w_mod_rem] = 1'b1;
                        n_icount               = r_icount + CNT_W'(1);
                        n_done                 = 1'b1;
                    end
                end
            end
            S_WALK: begin
                if (r_opcode == OP_LOOKUP && w_key_match) begin
                    n_done               = 1'b1;
                    n_result.found       = 1'b1;
                    n_result.result_addr = w_rd.data.addr;
                end else if (w_rd.link.has_next) begin
                    // Advance along the chain
                    w_req.rd_en   = 1'b1;
                    w_req.rd_addr = w_rd.link.next;
                    n_cur         = w_rd.link.next;
                end else if (r_opcode == OP_LOOKUP) begin
                    n_done          = 1'b1;
                    n_result.status = ST_MISS;
                end else if (w_ovf_full) begin
                    n_done          = 1'b1;
                    n_result.status = ST_FULL;
                end else begin
                    // Link the tail to a fresh overflow node and store the entry
                    w_req.l_we             = 1'b1;
                    w_req.l_waddr          = r_cur;
                    w_req.l_wdata.has_next = 1'b1;
                    w_req.l_wdata.next     = w_node;
                    w_req.d_we             = 1'b1;
                    w_req.d_waddr          = w_node;
                    w_req.d_wdata.key      = r_key;
                    w_req.d_wdata.addr     = r_addr;
                end
            end
            S_LINK: begin
                // Terminate the new node and take it into use
                w_req.l_we    = 1'b1;
                w_req.l_waddr = w_node;
                n_fill        = r_fill + CNT_W'(1);
                n_icount      = r_icount + CNT_W'(1);
                n_done        = 1'b1;
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_done       <= 1'b0;
            r_bkt_valid  <= '0;
            r_icount     <= '0;
            r_fill       <= '0;
            r_table_size <= SIZE_W'(MAX_ENTRIES);
        end else begin
            r_state     <= n_state;
            r_done      <= n_done;
            r_bkt_valid <= n_bkt_valid;
            r_icount    <= n_icount;
            r_fill      <= n_fill;
            if (i_cfg_we) begin
                r_table_size <= i_cfg_data;
            end
        end
    end

    // Transaction and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_opcode <= i_item.opcode;
            r_key    <= i_item.key;
            r_addr   <= i_item.code_addr;
        end
        r_cur <= n_cur;
        if (n_done) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // Checks
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (busy || o_done))
        else $error("accepted transaction neither in progress nor answered");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WALK |-> $past(w_req.rd_en))
        else $error("chain entry evaluated without a read issued");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_icount)
        else $error("overflow fill exceeds insert count");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_icount <= CNT_W'(MAX_ENTRIES))
        else $error("insert count beyond table capacity");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.found) |-> (o_result.status == ST_OK))
        else $error("match reported with a failing status");

endmodule

@@ tb/sv/chl_lookup_checker.sv @@
// Checker for the chained hash lookup table: keeps a shadow copy of the table,
// predicts the answer to every command transaction and compares it with the
// result strobe. Depends on chl_pkg.
module chl_lookup_checker
    import chl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  t_item             i_item,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_data,
    input  logic              i_done,
    input  t_result           i_result,
    output int                o_mismatches,
    output int                o_in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [SIZE_W-1:0] SIZE_AT_RESET = 9'd256;
    localparam int                REPORT_LIMIT  = 10;

    // Shadow table: buckets first, overflow nodes after them
    logic              tbl_valid    [SLOTS];
    logic [KEY_W-1:0]  tbl_key      [SLOTS];
    logic [ADDR_W-1:0] tbl_addr     [SLOTS];
    logic [IDX_W-1:0]  tbl_next     [SLOTS];
    logic              tbl_has_next [SLOTS];
    int unsigned       ovf_fill;
    int unsigned       ins_count;
    logic [SIZE_W-1:0] size_reg;

    // Answers owed by the block, oldest first
    t_result answer_q[$];
    int      fails = 0;

    function automatic void clear_shadow();
        for (int i = 0; i < SLOTS; i++) begin
            tbl_valid[i]    = 1'b0;
            tbl_has_next[i] = 1'b0;
        end
        ovf_fill  = 0;
        ins_count = 0;
    endfunction

    function automatic void note_fault(string msg);
        fails++;
        if (fails <= REPORT_LIMIT)
            $display("%0t: %s", $time, msg);
    endfunction

    // Apply one command to the shadow table and return the answer it owes
    function automatic t_result apply_command(t_item cmd);
        int unsigned eff;
        int unsigned cur;
        int unsigned node;
        int unsigned steps;
        t_result     ans;
        eff = size_reg;
        if (eff == 0) eff = 1;
        if (eff > MAX_ENTRIES) eff = MAX_ENTRIES;
        cur = cmd.key % eff;
        ans = '0;
        case (cmd.opcode)
            OP_CLEAR: begin
                clear_shadow();
            end
            OP_INSERT: begin
                if (ins_count >= eff) begin
                    ans.status = ST_FULL;
                end else if (!tbl_valid[cur]) begin
                    tbl_valid[cur]    = 1'b1;
                    tbl_key[cur]      = cmd.key;
                    tbl_addr[cur]     = cmd.code_addr;
                    tbl_has_next[cur] = 1'b0;
                    ins_count++;
                end else begin
                    // walk to the tail and append a fresh overflow node
                    node  = MAX_ENTRIES + ovf_fill;
                    steps = 0;
                    while (steps < SLOTS && tbl_has_next[cur]) begin
                        cur = tbl_next[cur];
                        steps++;
                    end
                    if (node < SLOTS) begin
                        tbl_next[cur]      = IDX_W'(node);
                        tbl_has_next[cur]  = 1'b1;
                        tbl_valid[node]    = 1'b1;
                        tbl_key[node]      = cmd.key;
                        tbl_addr[node]     = cmd.code_addr;
                        tbl_has_next[node] = 1'b0;
                        ovf_fill++;
                        ins_count++;
                    end else begin
                        ans.status = ST_FULL;
                    end
                end
            end
            OP_LOOKUP: begin
                ans.status = ST_MISS;
                if (tbl_valid[cur]) begin
                    for (steps = 0; steps < SLOTS; steps++) begin
                        if (tbl_key[cur] == cmd.key) begin
                            ans.found       = 1'b1;
                            ans.result_addr = tbl_addr[cur];
                            ans.status      = ST_OK;
                            break;
                        end
                        if (!tbl_has_next[cur]) break;
                        cur = tbl_next[cur];
                    end
                end
            end
            default: begin
                // unused opcode: no change, all-zero answer
            end
        endcase
        return ans;
    endfunction

    // Check the strobe, then take configuration and new transactions
    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            clear_shadow();
            size_reg = SIZE_AT_RESET;
            answer_q.delete();
        end else begin
            if (i_done) begin
                if (answer_q.size() == 0) begin
                    note_fault($sformatf("result with nothing pending: found=%0d addr=%h status=%0d",
                                         i_result.found, i_result.result_addr, i_result.status));
                end else begin
                    want = answer_q.pop_front();
                    if (i_result.found !== want.found ||
                        i_result.result_addr !== want.result_addr ||
                        i_result.status !== want.status)
                        note_fault($sformatf({"mismatch: expected found=%0d addr=%h status=%0d,",
                                              " got found=%0d addr=%h status=%0d"},
                                             want.found, want.result_addr, want.status,
                                             i_result.found, i_result.result_addr,
                                             i_result.status));
                end
            end
            if (i_cfg_we)
                size_reg = i_cfg_data;
            if (i_start && !i_busy)
                answer_q.push_back(apply_command(i_item));
        end
        o_mismatches <= fails;
        o_in_flight  <= answer_q.size();
    end

endmodule

@@ tb/sv/tb_chained_hash_lookup_table.sv @@
// Testbench top for the chained hash lookup table: clock, reset, command and
// size-register stimulus, watchdog and verdict. Depends on chl_pkg,
// chained_hash_lookup_table and chl_lookup_checker.
module tb_chained_hash_lookup_table;
    timeunit 1ns;
    timeprecision 1ps;
    import chl_pkg::*;

    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam int         RAND_ITEMS     = 1050;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         DRAIN_CYCLES   = 20;
    localparam int         POOL_DEPTH     = 64;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              start      = 1'b0;
    logic              busy;
    t_item             i_item     = '0;
    logic              i_cfg_we   = 1'b0;
    logic [SIZE_W-1:0] i_cfg_data = '0;
    logic              o_done;
    t_result           o_result;

    int mismatches;
    int in_flight;
    int idle_cycles = 0;

    // Stimulus knobs, changed per phase
    logic [SIZE_W-1:0] cur_size    = 9'd256;
    bit                no_idle     = 1'b0;
    int unsigned       hot_buckets = 4;
    int unsigned       collide_pct = 35;
    int unsigned       insert_pct  = 48;
    logic [KEY_W-1:0]  key_pool[$];

    always #5 i_clk = ~i_clk;

    chained_hash_lookup_table dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_done     (o_done),
        .o_result   (o_result)
    );

    chl_lookup_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_done       (o_done),
        .i_result     (o_result),
        .o_mismatches (mismatches),
        .o_in_flight  (in_flight)
    );

    // Watchdog: count cycles in which no transaction and no result moves
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("chained_hash_lookup_table verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_item mk(logic [1:0] op, logic [KEY_W-1:0] k, logic [ADDR_W-1:0] a);
        t_item it;
        it.opcode    = op;
        it.key       = k;
        it.code_addr = a;
        return it;
    endfunction

    function automatic int eff_size();
        if (cur_size == 0) return 1;
        if (cur_size > MAX_ENTRIES) return MAX_ENTRIES;
        return cur_size;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int unsigned r;
        if (no_idle) return 0;
        r = $urandom_range(99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    // Keys: reuse of earlier keys, collisions on a few hot buckets, or noise
    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned r;
        int unsigned base;
        int unsigned mult;
        r = $urandom_range(99);
        if (r < 40 && key_pool.size() > 0)
            return key_pool[$urandom_range(key_pool.size() - 1)];
        if (r < 40 + collide_pct) begin
            base = $urandom_range(hot_buckets - 1);
            mult = $urandom_range(65535 / eff_size());
            return KEY_W'(base + eff_size() * mult);
        end
        return KEY_W'($urandom);
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) return SIZE_W'($urandom_range(1));
        if (r < 20) begin
            case ($urandom_range(3))
                0:       return 9'd255;
                1:       return 9'd256;
                2:       return 9'd257;
                default: return 9'd511;
            endcase
        end
        if (r < 60) return SIZE_W'($urandom_range(16, 2));
        if (r < 80) return SIZE_W'($urandom_range(64, 17));
        return SIZE_W'($urandom);
    endfunction

    // Present one command and hold it until the block takes it
    task automatic issue(input t_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_item <= it;
        start  <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Stop sending and wait for every owed result
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (in_flight != 0) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] sz);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= sz;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_size = sz;
    endtask

    initial begin : stimulus
        int          rand_sent;
        int          phase;
        int          n;
        int unsigned r;
        logic [1:0]  op;
        logic [KEY_W-1:0] k;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, chains, duplicates, unused opcode, clear
        issue(mk(OP_LOOKUP, 16'h0000, 32'h0));
        issue(mk(OP_INSERT, 16'h0000, 32'hFFFF_FFFF));
        issue(mk(OP_INSERT, 16'hFFFF, 32'h0000_0000));
        issue(mk(OP_INSERT, 16'h0100, 32'h1234_5678));
        issue(mk(OP_INSERT, 16'h0000, 32'hA5A5_A5A5));
        issue(mk(OP_INSERT, 16'h0200, 32'h5A5A_5A5A));
        issue(mk(OP_LOOKUP, 16'h0000, 32'h0));
        issue(mk(OP_LOOKUP, 16'h0200, 32'h0));
        issue(mk(OP_LOOKUP, 16'h0300, 32'h0));
        issue(mk(OP_LOOKUP, 16'hFFFF, 32'h0));
        issue(mk(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF));
        issue(mk(OP_LOOKUP, 16'hFFFF, 32'h0));
        issue(mk(OP_CLEAR, 16'hFFFF, 32'hFFFF_FFFF));
        issue(mk(OP_LOOKUP, 16'h0000, 32'h0));

        // Size zero acts as one: second insert is refused
        write_size(9'd0);
        issue(mk(OP_INSERT, 16'h0007, 32'h0000_0001));
        issue(mk(OP_INSERT, 16'h0009, 32'h0000_0002));
        issue(mk(OP_LOOKUP, 16'h0007, 32'h0));
        issue(mk(OP_LOOKUP, 16'h0009, 32'h0));

        // Size above the maximum, then lookups under a changed size
        write_size(9'd511);
        issue(mk(OP_INSERT, 16'd300, 32'hDEAD_BEEF));
        issue(mk(OP_LOOKUP, 16'h0007, 32'h0));
        write_size(9'd4);
        issue(mk(OP_INSERT, 16'h0001, 32'h0000_0011));
        issue(mk(OP_INSERT, 16'h0005, 32'h0000_0055));

        // Size lowered below the fill: inserts refused, lookups may miss
        write_size(9'd2);
        issue(mk(OP_INSERT, 16'h0003, 32'h0000_0033));
        issue(mk(OP_LOOKUP, 16'd300, 32'h0));
        issue(mk(OP_LOOKUP, 16'h0005, 32'h0));

        // Random phases, each at one table size
        rand_sent = 0;
        phase     = 0;
        while (rand_sent < RAND_ITEMS) begin
            if (phase == 2) begin
                // one hot bucket at full size: long chains to walk
                write_size(9'd256);
                hot_buckets = 1;
                collide_pct = 50;
                insert_pct  = 70;
                n           = 200;
            end else begin
                write_size(pick_size());
                hot_buckets = $urandom_range(4, 1);
                collide_pct = $urandom_range(50, 10);
                insert_pct  = $urandom_range(65, 35);
                n           = $urandom_range(120, 40);
            end
            // Stop at the item budget
            if (n > RAND_ITEMS - rand_sent) n = RAND_ITEMS - rand_sent;
            no_idle = ($urandom_range(3) == 0);
            if (phase == 2 || $urandom_range(1) == 0)
                issue(mk(OP_CLEAR, KEY_W'($urandom), $urandom));
            repeat (n) begin
                r = $urandom_range(99);
                if (r < 2)                   op = OP_CLEAR;
                else if (r < 4)              op = OP_UNUSED;
                else if (r < 4 + insert_pct) op = OP_INSERT;
                else                         op = OP_LOOKUP;
                k = pick_key();
                if (op == OP_INSERT) begin
                    key_pool.push_back(k);
                    if (key_pool.size() > POOL_DEPTH) key_pool.delete(0);
                end
                issue(mk(op, k, $urandom));
                rand_sent++;
            end
            phase++;
        end

        // Drain, let the block settle, then give the verdict
        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && in_flight == 0)
            $display("chained_hash_lookup_table verification clean");
        else
            $display("chained_hash_lookup_table verification failed");
        $finish;
    end

endmodule
